// ===== rtl/multichannel_sample_mixer_top_macros.svh =====
// Assertion macros shared by the mixer RTL.
`ifndef MULTICHANNEL_SAMPLE_MIXER_TOP_MACROS_SVH
`define MULTICHANNEL_SAMPLE_MIXER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MSM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/msm_pkg.sv =====
// Shared types, constants and field widths of the sample mixer.
package msm_pkg;

  localparam int VOICES_DEF           = 32;
  localparam int SAMPLE_ADDR_BITS_DEF = 16;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 72;

  localparam int END_W  = 18;
  localparam int FRAC_W = 16;
  localparam int STEP_W = 20;
  localparam int RATE_W = 16;
  localparam int GAIN_W = 7;
  localparam int ACC_W  = 24;
  localparam int DIV_W  = 32;

  localparam logic [STEP_W-1:0] STEP_MAX  = 20'hFFFFF;
  localparam logic [22:0]       RECIP_K   = 23'd5621684;  // floor(2^30 / 191)
  localparam logic [7:0]        SCALE_DIV = 8'd191;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_START  = 3'd1,
    OP_PARAMS = 3'd2,
    OP_STOP   = 3'd3,
    OP_MIX    = 3'd4
  } opcode_t;

  localparam logic [1:0] CFG_OUTPUT_RATE = 2'd0;
  localparam logic [1:0] CFG_FLIP_PAN    = 2'd1;
  localparam logic [1:0] CFG_SOUND_EN    = 2'd2;

endpackage

// ===== rtl/msm_smem.sv =====
// Sample byte memory: one write port, one registered read port.
module msm_smem import msm_pkg::*; #(
  parameter int SAMPLE_ADDR_BITS = SAMPLE_ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [SAMPLE_ADDR_BITS-1:0] waddr,
  input  logic [7:0]                  wdata,
  input  logic [SAMPLE_ADDR_BITS-1:0] raddr,
  output logic [7:0]                  rdata
);

  logic [7:0] mem [2**SAMPLE_ADDR_BITS];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/msm_vmem.sv =====
// Per-voice state memory; entries never written read back as zero.
module msm_vmem import msm_pkg::*; #(
  parameter int VOICES = VOICES_DEF,
  parameter int ENT_W  = 8,
  localparam int CHB   = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [CHB-1:0]   waddr,
  input  logic [ENT_W-1:0] wdata,
  input  logic [CHB-1:0]   raddr,
  output logic [ENT_W-1:0] rdata
);

  logic [ENT_W-1:0]  mem_r [VOICES];
  logic [VOICES-1:0] written_r;
  logic [ENT_W-1:0]  rd_r;
  logic              rd_ok_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_r <= mem_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rd_ok_r   <= 1'b0;
    end else begin
      if (we) begin
        written_r[waddr] <= 1'b1;
      end
      rd_ok_r <= written_r[raddr];
    end
  end

  assign rdata = rd_ok_r ? rd_r : '0;

endmodule

// ===== rtl/msm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module msm_div import msm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [15:0]      divisor,
  output logic             busy,
  output logic [DIV_W-1:0] quotient
);

  logic [5:0]       cnt_r;
  logic             busy_r;
  logic [DIV_W-1:0] q_r;
  logic [15:0]      rem_r;
  logic [15:0]      dsr_r;
  logic [16:0]      sh;
  logic [16:0]      diff;

  assign sh   = {rem_r, q_r[DIV_W-1]};
  assign diff = sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'(DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      // Remainder stays below the divisor, so 16 bits hold it.
      if (sh >= {1'b0, dsr_r}) begin
        rem_r <= diff[15:0];
        q_r   <= {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= sh[15:0];
        q_r   <= {q_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

// ===== rtl/multichannel_sample_mixer_top.sv =====
// Top level of the sample mixer: sequencer, mixing datapath and configuration.
//
//   port group | dir | contents
//   in_*       | in  | one operation word: tuser opcode, tdata operands
//   out_*      | out | one result word per operation
//   cfg_*      | in  | register writes, no read-back
//
// Write byte, stop and unknown opcodes go straight to the final state; start and set params
// wait on the 32-step divider for the pitch step.
// Mix checks every voice in turn and makes two sample reads per active voice
// on the single sample memory read port.
// Reset is synchronous and needs no clearing pass; voice entries carry valid bits.
// A result waiting on out_tready holds the block in its final state.
`include "multichannel_sample_mixer_top_macros.svh"

module multichannel_sample_mixer_top import msm_pkg::*; #(
  parameter int VOICES           = VOICES_DEF,
  parameter int SAMPLE_ADDR_BITS = SAMPLE_ADDR_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // channel, address, lump_length, sample_byte, volume, separation, in_left, in_right
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic [2:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // left_out, right_out, handle, playing_mask
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_wdata
);

  localparam int CHB   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW    = SAMPLE_ADDR_BITS;
  localparam int ENT_W = AW + END_W + FRAC_W + STEP_W + RATE_W + 2 * GAIN_W;
  localparam logic [CHB-1:0] LAST_CH = CHB'(VOICES - 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_FIN, ST_ST_LO, ST_ST_HI, ST_ST_RATE, ST_P_RD, ST_P_LAT,
    ST_G0, ST_G1, ST_G2, ST_G_WAIT, ST_M_CHK, ST_M_VRD, ST_M_S0, ST_M_S1,
    ST_M_INT, ST_M_REC, ST_M_COR
  } state_t;

  function automatic logic [15:0] sat16(input logic signed [ACC_W-1:0] a);
    logic [15:0] r;
    if (a > ACC_W'(32767)) begin
      r = 16'h7FFF;
    end else if (a < -ACC_W'(32768)) begin
      r = 16'h8000;
    end else begin
      r = a[15:0];
    end
    return r;
  endfunction

  // Corrects the reciprocal estimate of m / 191 by at most one.
  function automatic logic [14:0] div191(input logic [21:0] m, input logic [44:0] mk);
    logic [14:0] q0;
    logic [22:0] t;
    logic [21:0] r;
    q0 = mk[44:30];
    t  = q0 * SCALE_DIV;
    r  = m - t[21:0];
    return q0 + 15'(r >= 22'(SCALE_DIV));
  endfunction

  // Configuration
  logic [15:0] out_rate_r;
  logic        flip_r;
  logic        en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_rate_r <= 16'd11025;
      flip_r     <= 1'b0;
      en_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OUTPUT_RATE: out_rate_r <= cfg_wdata;
        CFG_FLIP_PAN:    flip_r     <= cfg_wdata[0];
        CFG_SOUND_EN:    en_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input word fields
  logic [4:0]         in_ch;
  logic [15:0]        in_addr, in_len, in_left, in_right;
  logic [7:0]         in_byte, in_sep;
  logic [3:0]         in_vol;
  logic               in_acc;
  logic               ch_ok;

  assign in_ch    = in_tdata[4:0];
  assign in_addr  = in_tdata[20:5];
  assign in_len   = in_tdata[36:21];
  assign in_byte  = in_tdata[44:37];
  assign in_vol   = in_tdata[48:45];
  assign in_sep   = in_tdata[56:49];
  assign in_left  = in_tdata[72:57];
  assign in_right = in_tdata[88:73];

  state_t state_r, state_nxt;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign ch_ok     = {2'b00, in_ch} < 7'(VOICES);

  // Control and datapath registers
  logic [CHB-1:0]    nh_r, nh_inc, ch_r, vc_r;
  logic [VOICES-1:0] active_r;
  logic              out_valid_r;
  logic [15:0]       out_left_r, out_right_r;
  logic [4:0]        out_handle_r;
  logic [31:0]       out_mask_r;
  logic              out_free;

  logic [2:0]        op_r;
  logic [AW-1:0]     addr_r;
  logic [15:0]       len_r;
  logic [3:0]        vol_r;
  logic [7:0]        sep_r;
  logic [7:0]        lo_r, d0_r;
  logic signed [ACC_W-1:0] acc_l_r, acc_r_r;

  logic [AW-1:0]           e_pos_r;
  logic signed [END_W-1:0] e_end_r;
  logic [FRAC_W-1:0]       e_frac_r;
  logic [STEP_W-1:0]       e_step_r;
  logic [RATE_W-1:0]       e_rate_r;
  logic [GAIN_W-1:0]       e_lg_r, e_rg_r;

  logic [16:0]        sq_r;
  logic [24:0]        p0_r;
  logic [23:0]        p1_r;
  logic signed [16:0] pl_r, pr_r;
  logic [21:0]        ml_r, mr_r;
  logic [44:0]        kl_r, kr_r;
  logic               negl_r, negr_r;

  assign nh_inc   = (nh_r == LAST_CH) ? '0 : nh_r + 1'b1;
  assign out_free = !out_valid_r || out_tready;

  // Memories
  logic              sm_we;
  logic [AW-1:0]     sm_raddr;
  logic [7:0]        sm_rdata;
  logic              vm_we;
  logic [CHB-1:0]    vm_waddr, vm_raddr;
  logic [ENT_W-1:0]  vm_wdata, vm_rdata;

  logic [AW-1:0]           v_pos;
  logic signed [END_W-1:0] v_end;
  logic [FRAC_W-1:0]       v_frac;
  logic [STEP_W-1:0]       v_step;
  logic [RATE_W-1:0]       v_rate;
  logic [GAIN_W-1:0]       v_lg, v_rg;

  assign {v_pos, v_end, v_frac, v_step, v_rate, v_lg, v_rg} = vm_rdata;

  msm_smem #(.SAMPLE_ADDR_BITS(AW)) u_smem (
    .clk   (clk),
    .we    (sm_we),
    .waddr (AW'(in_addr)),
    .wdata (in_byte),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  msm_vmem #(.VOICES(VOICES), .ENT_W(ENT_W)) u_vmem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (vm_we),
    .waddr (vm_waddr),
    .wdata (vm_wdata),
    .raddr (vm_raddr),
    .rdata (vm_rdata)
  );

  // Divider for the step: a 16.16 quotient saturated to 4.16
  logic             div_start, div_busy;
  logic [15:0]      div_rate;
  logic [DIV_W-1:0] div_q;
  logic [STEP_W-1:0] step_sat;

  assign div_start = (state_r == ST_ST_RATE) || (state_r == ST_P_LAT);
  assign div_rate  = (state_r == ST_ST_RATE) ? {sm_rdata, lo_r} : v_rate;
  assign step_sat  = ((out_rate_r == '0) || (div_q[DIV_W-1:STEP_W] != '0)) ?
                     STEP_MAX : div_q[STEP_W-1:0];

  msm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({div_rate, 16'h0000}),
    .divisor  (out_rate_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Pan gain arithmetic
  logic [8:0]  s9, sl, sr;
  logic [6:0]  v7;
  logic [23:0] prodv;

  assign s9    = {1'b0, sep_r} + 9'd1;
  assign sl    = flip_r ? 9'd257 - s9 : s9;
  assign sr    = 9'd257 - sl;
  assign v7    = {vol_r, 3'b000};
  assign prodv = v7 * sq_r;

  // Voice advance and scaling results
  logic [20:0]             fsum;
  logic [4:0]              adv;
  logic [AW-1:0]           pos_new;
  logic signed [END_W-1:0] end_new;
  logic                    end_hit;
  logic [24:0]             psum;
  logic signed [8:0]       sc;
  logic [16:0]             magl, magr;
  logic [14:0]             ql, qr;
  logic signed [ACC_W-1:0] cl, cr;

  assign fsum    = 21'(e_frac_r) + 21'(e_step_r);
  assign adv     = fsum[20:16];
  assign pos_new = e_pos_r + AW'(adv);
  assign end_new = e_end_r - $signed({13'b0, adv});
  assign end_hit = end_new[END_W-1] || (end_new == '0);
  assign psum    = p0_r + 25'(p1_r);
  assign sc      = $signed({1'b0, psum[23:16]}) - 9'sd128;
  assign magl    = pl_r[16] ? 17'(-pl_r) : 17'(pl_r);
  assign magr    = pr_r[16] ? 17'(-pr_r) : 17'(pr_r);
  assign ql      = div191(ml_r, kl_r);
  assign qr      = div191(mr_r, kr_r);
  assign cl      = negl_r ? -$signed(ACC_W'(ql)) : $signed(ACC_W'(ql));
  assign cr      = negr_r ? -$signed(ACC_W'(qr)) : $signed(ACC_W'(qr));

  // Memory port control
  always_comb begin
    sm_we    = in_acc && en_r && (in_tuser == OP_WRITE);
    vm_we    = ((state_r == ST_G_WAIT) && !div_busy) || (state_r == ST_M_COR);
    vm_waddr = (state_r == ST_G_WAIT) ? ch_r : vc_r;
    vm_raddr = (state_r == ST_P_RD) ? ch_r : vc_r;
    case (state_r)
      ST_ST_LO: sm_raddr = addr_r + AW'(2);
      ST_ST_HI: sm_raddr = addr_r + AW'(3);
      ST_M_VRD: sm_raddr = v_pos;
      ST_M_S0:  sm_raddr = e_pos_r + AW'(1);
      default:  sm_raddr = e_pos_r;
    endcase
    if (state_r == ST_G_WAIT) begin
      vm_wdata = {e_pos_r, e_end_r, e_frac_r, step_sat, e_rate_r, e_lg_r, e_rg_r};
    end else begin
      vm_wdata = {pos_new, end_new, fsum[15:0], e_step_r, e_rate_r, e_lg_r, e_rg_r};
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!en_r) begin
            state_nxt = ST_FIN;
          end else begin
            unique case (in_tuser)
              OP_START:  state_nxt = ST_ST_LO;
              OP_PARAMS: state_nxt = ch_ok ? ST_P_RD : ST_FIN;
              OP_MIX:    state_nxt = ST_M_CHK;
              default:   state_nxt = ST_FIN;
            endcase
          end
        end
      end
      ST_ST_LO:   state_nxt = ST_ST_HI;
      ST_ST_HI:   state_nxt = ST_ST_RATE;
      ST_ST_RATE: state_nxt = ST_G0;
      ST_P_RD:    state_nxt = ST_P_LAT;
      ST_P_LAT:   state_nxt = ST_G0;
      ST_G0:      state_nxt = ST_G1;
      ST_G1:      state_nxt = ST_G2;
      ST_G2:      state_nxt = ST_G_WAIT;
      ST_G_WAIT:  state_nxt = div_busy ? ST_G_WAIT : ST_FIN;
      ST_M_CHK: begin
        if (active_r[vc_r]) begin
          state_nxt = ST_M_VRD;
        end else if (vc_r == LAST_CH) begin
          state_nxt = ST_FIN;
        end
      end
      ST_M_VRD:   state_nxt = ST_M_S0;
      ST_M_S0:    state_nxt = ST_M_S1;
      ST_M_S1:    state_nxt = ST_M_INT;
      ST_M_INT:   state_nxt = ST_M_REC;
      ST_M_REC:   state_nxt = ST_M_COR;
      ST_M_COR:   state_nxt = (vc_r == LAST_CH) ? ST_FIN : ST_M_CHK;
      ST_FIN:     state_nxt = out_free ? ST_IDLE : ST_FIN;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // State, voice activity, round-robin handle and the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      nh_r        <= LAST_CH;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && en_r && (in_tuser == OP_STOP) && ch_ok) begin
        active_r[CHB'(in_ch)] <= 1'b0;
      end
      if (in_acc && en_r && (in_tuser == OP_START)) begin
        nh_r <= nh_inc;
      end
      if ((state_r == ST_G_WAIT) && !div_busy && (op_r == OP_START)) begin
        active_r[ch_r] <= 1'b1;
      end
      if ((state_r == ST_M_COR) && end_hit) begin
        active_r[vc_r] <= 1'b0;
      end
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r  <= 1'b1;
        out_left_r   <= sat16(acc_l_r);
        out_right_r  <= sat16(acc_r_r);
        out_handle_r <= 5'(nh_r);
        out_mask_r   <= en_r ? 32'(active_r) : 32'h0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operand capture and mixing datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_r    <= in_tuser;
          addr_r  <= AW'(in_addr);
          len_r   <= in_len;
          vol_r   <= in_vol;
          sep_r   <= in_sep;
          acc_l_r <= ACC_W'($signed(in_left));
          acc_r_r <= ACC_W'($signed(in_right));
          ch_r    <= (in_tuser == OP_START) ? nh_inc : CHB'(in_ch);
          vc_r    <= '0;
        end
      end
      ST_ST_HI: lo_r <= sm_rdata;
      ST_ST_RATE: begin
        e_rate_r <= {sm_rdata, lo_r};
        e_pos_r  <= addr_r + AW'(8);
        e_end_r  <= $signed({2'b00, len_r}) - 18'sd17;
        e_frac_r <= '0;
      end
      ST_P_LAT, ST_M_VRD: begin
        e_pos_r  <= v_pos;
        e_end_r  <= v_end;
        e_frac_r <= v_frac;
        e_step_r <= v_step;
        e_rate_r <= v_rate;
        e_lg_r   <= v_lg;
        e_rg_r   <= v_rg;
      end
      ST_G0: sq_r <= sl * sl;
      ST_G1: begin
        e_lg_r <= v7 - prodv[22:16];
        sq_r   <= sr * sr;
      end
      ST_G2: e_rg_r <= v7 - prodv[22:16];
      ST_G_WAIT: e_step_r <= step_sat;
      ST_M_CHK: begin
        if (!active_r[vc_r] && (vc_r != LAST_CH)) begin
          vc_r <= vc_r + 1'b1;
        end
      end
      ST_M_S0: d0_r <= sm_rdata;
      ST_M_S1: begin
        p0_r <= d0_r * (17'h10000 - 17'(e_frac_r));
        p1_r <= sm_rdata * e_frac_r;
      end
      ST_M_INT: begin
        pl_r <= $signed({1'b0, e_lg_r}) * sc;
        pr_r <= $signed({1'b0, e_rg_r}) * sc;
      end
      ST_M_REC: begin
        // Magnitudes stay below 2^14, so the scaled operand fits 22 bits.
        ml_r   <= {magl[13:0], 8'h00};
        mr_r   <= {magr[13:0], 8'h00};
        kl_r   <= {magl[13:0], 8'h00} * RECIP_K;
        kr_r   <= {magr[13:0], 8'h00} * RECIP_K;
        negl_r <= pl_r[16];
        negr_r <= pr_r[16];
      end
      ST_M_COR: begin
        acc_l_r <= acc_l_r + cl;
        acc_r_r <= acc_r_r + cr;
        if (vc_r != LAST_CH) begin
          vc_r <= vc_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_mask_r, out_handle_r, out_right_r, out_left_r};

  `MSM_ASSERT_NEXT(a_accept_blocks, in_tvalid && in_tready, !in_tready, "input word taken while busy")
  `MSM_ASSERT_SAME(a_vmem_write_busy, vm_we, !in_tready, "voice write outside an operation")
  `MSM_ASSERT_SAME(a_fin_div_idle, state_r == ST_FIN, !div_busy, "result formed while dividing")

endmodule

// ===== test/tb_multichannel_sample_mixer_top.sv =====
// Self-checking testbench for the multichannel sample mixer top level.
module tb_multichannel_sample_mixer_top import msm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]         op;
    logic [4:0]         ch;
    logic [15:0]        addr;
    logic [15:0]        len;
    logic [7:0]         sbyte;
    logic [3:0]         vol;
    logic [7:0]         sep;
    logic signed [15:0] lin;
    logic signed [15:0] rin;
  } mix_op_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [4:0]         hnd;
    logic [31:0]        mask;
  } mix_res_t;

  localparam logic [15:0] REGION_BASE = 16'hFF00;
  localparam int          REGION_SIZE = 384;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [2:0]             in_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [1:0]             cfg_index;
  logic [15:0]            cfg_wdata;

  multichannel_sample_mixer_top dut (.*);

  // Predictor state.
  logic [7:0]  mem [0:65535];
  logic [15:0] v_pos [32];
  int          v_end [32];
  int unsigned v_frac [32];
  int unsigned v_step [32];
  int unsigned v_rate [32];
  int          g_left [32];
  int          g_right [32];
  bit          v_act [32];
  logic [4:0]  last_handle;
  int unsigned out_rate;
  bit          pan_flip, snd_on;

  mix_op_t  pending_ops[$];
  mix_res_t want_results[$];
  mix_op_t  held_op;
  int       n_queued, n_checked, errors, in_gap, out_gap;
  bit       idle_on, hold_sender;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("FAIL multichannel_sample_mixer_top");
    $finish;
  end

  function automatic void set_gains(int ch, int vol, int sep);
    int s, v;
    if (out_rate == 0) v_step[ch] = 32'(STEP_MAX);
    else begin
      v_step[ch] = (v_rate[ch] << 16) / out_rate;
      if (v_step[ch] > STEP_MAX) v_step[ch] = 32'(STEP_MAX);
    end
    s = sep + 1;
    if (pan_flip) s = 257 - s;
    v = vol * 8;
    g_left[ch] = v - ((v * s * s) >>> 16);
    s = s - 257;
    g_right[ch] = v - ((v * s * s) >>> 16);
  endfunction

  function automatic int scaled(int gain, int unsigned s);
    return (gain * (int'(s) - 128) * 256) / 191;
  endfunction

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic mix_res_t apply_op(mix_op_t o);
    mix_res_t r;
    int dl, dr, ch;
    int unsigned d0, d1, f, s, adv;
    dl = int'(o.lin);
    dr = int'(o.rin);
    r.mask = '0;
    if (snd_on) begin
      case (o.op)
        OP_WRITE: mem[o.addr] = o.sbyte;
        OP_START: begin
          ch = (last_handle == 5'd31) ? 0 : int'(last_handle) + 1;
          last_handle = 5'(ch);
          v_rate[ch] = 32'({mem[o.addr + 16'd3], mem[o.addr + 16'd2]});
          v_pos[ch] = o.addr + 16'd8;
          v_end[ch] = int'(o.len) - 17;
          v_frac[ch] = 0;
          v_act[ch] = 1;
          set_gains(ch, int'(o.vol), int'(o.sep));
        end
        OP_PARAMS: set_gains(int'(o.ch), int'(o.vol), int'(o.sep));
        OP_STOP: v_act[o.ch] = 0;
        OP_MIX: begin
          for (int c = 0; c < 32; c++) begin
            if (!v_act[c]) continue;
            f = v_frac[c];
            d0 = 32'(mem[v_pos[c]]);
            d1 = 32'(mem[v_pos[c] + 16'd1]);
            s = (d0 * (32'h10000 - f) + d1 * f) >> 16;
            dl += scaled(g_left[c], s);
            dr += scaled(g_right[c], s);
            f += v_step[c];
            adv = f >> 16;
            v_pos[c] = v_pos[c] + adv[15:0];
            v_end[c] -= int'(adv);
            v_frac[c] = f & 32'hFFFF;
            if (v_end[c] <= 0) v_act[c] = 0;
          end
        end
        default: ;
      endcase
      for (int c = 0; c < 32; c++) r.mask[c] = v_act[c];
    end
    r.left = sat16(dl);
    r.right = sat16(dr);
    r.hnd = last_handle;
    return r;
  endfunction

  // Sender side.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
    end else begin
      if (in_tvalid && in_tready) want_results.push_back(apply_op(held_op));
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0 && !hold_sender) begin
          held_op = pending_ops.pop_front();
          in_tuser <= held_op.op;
          in_tdata <= {7'd0, held_op.rin, held_op.lin, held_op.sep, held_op.vol,
                       held_op.sbyte, held_op.len, held_op.addr, held_op.ch};
          in_tvalid <= 1'b1;
          if (idle_on && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 18);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver side.
  always @(posedge clk) begin
    mix_res_t w, g;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        g.left = out_tdata[15:0];
        g.right = out_tdata[31:16];
        g.hnd = out_tdata[36:32];
        g.mask = out_tdata[68:37];
        if (want_results.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          w = want_results.pop_front();
          if (g.left !== w.left) begin
            $error("left_out expected %0d got %0d", w.left, g.left); errors++;
          end
          if (g.right !== w.right) begin
            $error("right_out expected %0d got %0d", w.right, g.right); errors++;
          end
          if (g.hnd !== w.hnd) begin
            $error("handle expected %0d got %0d", w.hnd, g.hnd); errors++;
          end
          if (g.mask !== w.mask) begin
            $error("playing_mask expected %h got %h", w.mask, g.mask); errors++;
          end
        end
        n_checked++;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 11) == 0) out_gap = $urandom_range(1, 18);
      end
    end
  end

  task automatic queue_op(mix_op_t o);
    pending_ops.push_back(o);
    n_queued++;
  endtask

  function automatic mix_op_t make_op(logic [2:0] op);
    mix_op_t o;
    o.op = op;
    o.ch = 5'($urandom);
    o.addr = 16'($urandom);
    o.len = 16'($urandom_range(0, 300));
    o.sbyte = 8'($urandom);
    o.vol = 4'($urandom);
    o.sep = 8'($urandom);
    o.lin = 16'($urandom);
    o.rin = 16'($urandom);
    if ($urandom_range(0, 4) == 0) o.lin = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    if ($urandom_range(0, 4) == 0) o.rin = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    return o;
  endfunction

  // Handle the block handed out last; tracks starts made while enabled.
  logic [4:0] gen_handle;
  bit         gen_on;

  // A start whose header lies inside the written region, and for a short sound its whole body too.
  task automatic queue_start(int unsigned len, bit stop_now);
    mix_op_t o;
    o = make_op(OP_START);
    o.len = 16'(len);
    o.addr = REGION_BASE + 16'($urandom_range(0, REGION_SIZE - 316));
    queue_op(o);
    if (gen_on) gen_handle = gen_handle + 5'd1;
    // A long sound would run past the written region, so it is stopped at once.
    if (stop_now) begin
      o = make_op(OP_STOP);
      o.ch = gen_handle;
      queue_op(o);
    end
  endtask

  task automatic queue_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 15) queue_op(make_op(OP_WRITE));
      else if (k < 33) queue_start($urandom_range(0, 300), 1'b0);
      else if (k < 36) queue_start($urandom_range(301, 65535), 1'b1);
      else if (k < 50) queue_op(make_op(OP_PARAMS));
      else if (k < 58) queue_op(make_op(OP_STOP));
      else if (k < 95) queue_op(make_op(OP_MIX));
      else queue_op(make_op(3'($urandom_range(5, 7))));
    end
  endtask

  task automatic drain();
    wait (n_checked == n_queued);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_OUTPUT_RATE: out_rate = 32'(val);
      CFG_FLIP_PAN: pan_flip = val[0];
      CFG_SOUND_EN: snd_on = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    mix_op_t o;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    idle_on = 1;
    hold_sender = 0;
    in_gap = 0;
    out_gap = 0;
    n_queued = 0;
    n_checked = 0;
    errors = 0;
    for (int c = 0; c < 32; c++) begin
      v_pos[c] = 0; v_end[c] = 0; v_frac[c] = 0; v_step[c] = 0; v_rate[c] = 0;
      g_left[c] = 0; g_right[c] = 0; v_act[c] = 0;
    end
    last_handle = 5'd31;
    out_rate = 11025;
    pan_flip = 0;
    snd_on = 0;
    gen_handle = 5'd31;
    gen_on = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // While disabled every operation passes the stream through.
    for (int op = 0; op < 8; op++) queue_op(make_op(3'(op)));
    drain();

    reg_write(CFG_SOUND_EN, 16'd1);
    reg_write(CFG_OUTPUT_RATE, 16'd11025);
    reg_write(CFG_FLIP_PAN, 16'd0);
    gen_on = 1;
    // Fill a sample region that wraps past the top of memory.
    for (int i = 0; i < REGION_SIZE; i++) begin
      o = make_op(OP_WRITE);
      o.addr = REGION_BASE + 16'(i);
      queue_op(o);
    end

    // Directed: short and long sounds, pan extremes, saturation, odd opcodes.
    queue_start(9, 1'b0);
    queue_start(0, 1'b0);
    queue_start(16, 1'b0);
    queue_start(65535, 1'b1);
    queue_start(300, 1'b0);
    o = make_op(OP_PARAMS); o.ch = gen_handle; o.vol = 4'd15; o.sep = 8'd0; queue_op(o);
    o = make_op(OP_PARAMS); o.ch = 5'd0; o.vol = 4'd15; o.sep = 8'd255; queue_op(o);
    o = make_op(OP_PARAMS); o.ch = 5'd31; o.vol = 4'd0; o.sep = 8'd128; queue_op(o);
    o = make_op(OP_MIX); o.lin = 16'sh7FFF; o.rin = 16'sh8000; queue_op(o);
    o = make_op(OP_MIX); o.lin = 16'sh8000; o.rin = 16'sh7FFF; queue_op(o);
    for (int op = 5; op < 8; op++) queue_op(make_op(3'(op)));
    o = make_op(OP_STOP); o.ch = 5'd31; queue_op(o);
    o = make_op(OP_STOP); o.ch = 5'd0; queue_op(o);
    repeat (4) queue_op(make_op(OP_MIX));
    queue_random(100);
    // Sender holds off until everything in flight has come back.
    wait (pending_ops.size() == 0);
    hold_sender = 1;
    wait (n_checked == n_queued);
    hold_sender = 0;
    queue_random(100);
    drain();

    reg_write(CFG_OUTPUT_RATE, 16'd8000);
    reg_write(CFG_FLIP_PAN, 16'd1);
    queue_random(90);
    drain();

    reg_write(CFG_OUTPUT_RATE, 16'd65535);
    reg_write(CFG_FLIP_PAN, 16'd0);
    queue_random(70);
    drain();

    // Zero output rate saturates every new step; no idling from here on.
    idle_on = 0;
    reg_write(CFG_OUTPUT_RATE, 16'd0);
    queue_random(40);
    drain();

    reg_write(CFG_SOUND_EN, 16'd0);
    gen_on = 0;
    queue_random(20);
    drain();
    repeat (20) @(posedge clk);

    if (errors == 0 && want_results.size() == 0) begin
      $display("PASS multichannel_sample_mixer_top");
    end else begin
      $display("FAIL multichannel_sample_mixer_top");
    end
    $finish;
  end

endmodule

// ===== multichannel_sample_mixer_top.f =====
+incdir+rtl
rtl/msm_pkg.sv
rtl/msm_smem.sv
rtl/msm_vmem.sv
rtl/msm_div.sv
rtl/multichannel_sample_mixer_top.sv
test/tb_multichannel_sample_mixer_top.sv
